>>> design/torq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_pkg
// Shared types, widths, operation and status codes for the timestamp ordered
// request queue.
// ----------------------------------------------------------------------------
package torq_pkg;

    // Default sizing
    localparam int DEF_NUM_RESOURCES = 8;
    localparam int DEF_NUM_CLIENTS   = 16;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int RES_W    = 3;
    localparam int CLIENT_W = 4;
    localparam int STAMP_W  = 31;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int SLOTS_W  = 5;

    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

    // Operation codes (the unused code behaves as a query)
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    // One queue slot as held in the entry memory
    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [STAMP_W-1:0]  stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_PUT,
        ST_DONE
    } t_state;

endpackage

>>> design/torq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_if
// Valid/ready channels: configuration write, request beat, response beat.
// ----------------------------------------------------------------------------
interface torq_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [torq_pkg::SLOTS_W-1:0] active_slots;

    modport source (output valid, output active_slots, input ready);
    modport sink   (input valid, input active_slots, output ready);
endinterface

interface torq_req_if;
    logic                          valid;
    logic                          ready;
    logic [torq_pkg::KIND_W-1:0]   kind;
    logic [torq_pkg::RES_W-1:0]    resource;
    logic [torq_pkg::CLIENT_W-1:0] client;
    logic [torq_pkg::STAMP_W-1:0]  stamp;

    modport source (output valid, output kind, output resource, output client,
                    output stamp, input ready);
    modport sink   (input valid, input kind, input resource, input client,
                    input stamp, output ready);
endinterface

interface torq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          present;
    logic [torq_pkg::POS_W-1:0]    position;
    logic [torq_pkg::STAMP_W-1:0]  stored_stamp;
    logic [torq_pkg::STATUS_W-1:0] status;

    modport source (output valid, output present, output position,
                    output stored_stamp, output status, input ready);
    modport sink   (input valid, input present, input position,
                    input stored_stamp, input status, output ready);
endinterface

>>> design/torq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module torq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/torq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_seq
// Operation sequencer: reads the queue length, scans the queue slots in the
// entry memory, then shifts entries one per cycle and writes back.
// ----------------------------------------------------------------------------
module torq_seq #(
    parameter int NUM_RESOURCES = torq_pkg::DEF_NUM_RESOURCES,
    parameter int NUM_CLIENTS   = torq_pkg::DEF_NUM_CLIENTS,
    localparam int CW = $clog2(NUM_CLIENTS + 1),
    localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1,
    localparam int AW = $clog2(NUM_RESOURCES * NUM_CLIENTS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CW-1:0]                i_slots,
    torq_req_if.sink                     i_req,
    torq_rsp_if.source                   o_rsp,
    // entry memory
    output logic                         o_ent_rd_en,
    output logic [AW-1:0]                o_ent_rd_addr,
    input  logic [torq_pkg::ENTRY_W-1:0] i_ent_rd_data,
    output logic                         o_ent_wr_en,
    output logic [AW-1:0]                o_ent_wr_addr,
    output logic [torq_pkg::ENTRY_W-1:0] o_ent_wr_data,
    // queue length memory
    output logic                         o_fill_rd_en,
    output logic [RW-1:0]                o_fill_rd_addr,
    input  logic [CW-1:0]                i_fill_rd_data,
    output logic                         o_fill_wr_en,
    output logic [RW-1:0]                o_fill_wr_addr,
    output logic [CW-1:0]                o_fill_wr_data
);

    torq_pkg::t_state r_state, n_state;

    // operation registers
    logic [torq_pkg::KIND_W-1:0]     r_kind, n_kind;
    logic [torq_pkg::CLIENT_W-1:0]   r_client, n_client;
    logic [torq_pkg::STAMP_W-1:0]    r_stamp, n_stamp;
    logic [RW-1:0]                   r_res, n_res;
    logic [AW-1:0]                   r_base, n_base;
    logic                            r_fvld, n_fvld;
    logic [CW-1:0]                   r_len, n_len;
    logic [CW-1:0]                   r_idx, n_idx;
    logic                            r_found_hit, n_found_hit;
    logic [CW-1:0]                   r_found_idx, n_found_idx;
    logic [torq_pkg::STAMP_W-1:0]    r_found_stamp, n_found_stamp;
    logic                            r_at_hit, n_at_hit;
    logic [CW-1:0]                   r_at_idx, n_at_idx;
    logic [CW-1:0]                   r_ins, n_ins;
    logic                            r_back, n_back;
    // pending result
    logic                            r_res_present, n_res_present;
    logic [torq_pkg::POS_W-1:0]      r_res_pos, n_res_pos;
    logic [torq_pkg::STAMP_W-1:0]    r_res_stamp, n_res_stamp;
    logic [torq_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    // output register
    logic                            r_out_vld, n_out_vld;
    logic                            r_out_present, n_out_present;
    logic [torq_pkg::POS_W-1:0]      r_out_pos, n_out_pos;
    logic [torq_pkg::STAMP_W-1:0]    r_out_stamp, n_out_stamp;
    logic [torq_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    // queue length written since reset
    logic [NUM_RESOURCES-1:0]        r_fill_vld, n_fill_vld;

    torq_pkg::t_entry cur;
    torq_pkg::t_entry new_ent;
    logic [CW-1:0]    fill_len;
    logic [CW-1:0]    ins_at;
    logic [CW-1:0]    last_slot;

    assign cur             = torq_pkg::t_entry'(i_ent_rd_data);
    assign new_ent.client  = r_client;
    assign new_ent.stamp   = r_stamp;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= torq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_fill_vld <= '0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_fill_vld <= n_fill_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_client      <= n_client;
        r_stamp       <= n_stamp;
        r_res         <= n_res;
        r_base        <= n_base;
        r_fvld        <= n_fvld;
        r_len         <= n_len;
        r_idx         <= n_idx;
        r_found_hit   <= n_found_hit;
        r_found_idx   <= n_found_idx;
        r_found_stamp <= n_found_stamp;
        r_at_hit      <= n_at_hit;
        r_at_idx      <= n_at_idx;
        r_ins         <= n_ins;
        r_back        <= n_back;
        r_res_present <= n_res_present;
        r_res_pos     <= n_res_pos;
        r_res_stamp   <= n_res_stamp;
        r_res_status  <= n_res_status;
        r_out_present <= n_out_present;
        r_out_pos     <= n_out_pos;
        r_out_stamp   <= n_out_stamp;
        r_out_status  <= n_out_status;
    end

    // Next state, memory accesses and result
    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_client      = r_client;
        n_stamp       = r_stamp;
        n_res         = r_res;
        n_base        = r_base;
        n_fvld        = r_fvld;
        n_len         = r_len;
        n_idx         = r_idx;
        n_found_hit   = r_found_hit;
        n_found_idx   = r_found_idx;
        n_found_stamp = r_found_stamp;
        n_at_hit      = r_at_hit;
        n_at_idx      = r_at_idx;
        n_ins         = r_ins;
        n_back        = r_back;
        n_res_present = r_res_present;
        n_res_pos     = r_res_pos;
        n_res_stamp   = r_res_stamp;
        n_res_status  = r_res_status;
        n_out_vld     = r_out_vld;
        n_out_present = r_out_present;
        n_out_pos     = r_out_pos;
        n_out_stamp   = r_out_stamp;
        n_out_status  = r_out_status;
        n_fill_vld    = r_fill_vld;

        o_ent_rd_en    = 1'b0;
        o_ent_rd_addr  = r_base;
        o_ent_wr_en    = 1'b0;
        o_ent_wr_addr  = r_base;
        o_ent_wr_data  = i_ent_rd_data;
        o_fill_rd_en   = 1'b0;
        o_fill_rd_addr = RW'(i_req.resource);
        o_fill_wr_en   = 1'b0;
        o_fill_wr_addr = r_res;
        o_fill_wr_data = r_len;

        fill_len  = r_fvld ? i_fill_rd_data : '0;
        ins_at    = r_at_hit ? r_at_idx : r_len;
        last_slot = (r_len < i_slots) ? r_len : (i_slots - CW'(1));

        // response beat taken
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            torq_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_kind      = i_req.kind;
                    n_client    = i_req.client;
                    n_stamp     = i_req.stamp;
                    n_res       = RW'(i_req.resource);
                    n_base      = AW'(int'(i_req.resource) * NUM_CLIENTS);
                    n_fvld      = r_fill_vld[RW'(i_req.resource)];
                    n_found_hit = 1'b0;
                    n_at_hit    = 1'b0;
                    if (int'(i_req.resource) >= NUM_RESOURCES) begin
                        n_res_present = 1'b0;
                        n_res_pos     = '0;
                        n_res_stamp   = '0;
                        n_res_status  = torq_pkg::STAT_NOTFOUND;
                        n_state       = torq_pkg::ST_DONE;
                    end else begin
                        o_fill_rd_en = 1'b1;
                        n_state      = torq_pkg::ST_FILL;
                    end
                end
            end

            // queue length arrives, clip to slot count, start the scan
            torq_pkg::ST_FILL: begin
                n_len = (fill_len > i_slots) ? i_slots : fill_len;
                n_idx = '0;
                if (n_len != '0) begin
                    o_ent_rd_en   = 1'b1;
                    o_ent_rd_addr = r_base;
                    n_state       = torq_pkg::ST_SCAN;
                end else begin
                    n_state = torq_pkg::ST_DECIDE;
                end
            end

            // one slot per cycle: client match and insertion point
            torq_pkg::ST_SCAN: begin
                if (!r_found_hit && cur.client == r_client) begin
                    n_found_hit   = 1'b1;
                    n_found_idx   = r_idx;
                    n_found_stamp = cur.stamp;
                end
                if (!r_at_hit && (r_stamp < cur.stamp ||
                                  (r_stamp == cur.stamp && r_client < cur.client))) begin
                    n_at_hit = 1'b1;
                    n_at_idx = r_idx;
                end
                if ((r_idx + CW'(1)) < r_len) begin
                    o_ent_rd_en   = 1'b1;
                    o_ent_rd_addr = r_base + AW'(r_idx + CW'(1));
                    n_idx         = r_idx + CW'(1);
                end else begin
                    n_state = torq_pkg::ST_DECIDE;
                end
            end

            torq_pkg::ST_DECIDE: begin
                n_res_present = 1'b0;
                n_res_pos     = '0;
                n_res_stamp   = '0;
                n_res_status  = torq_pkg::STAT_NOTFOUND;
                n_state       = torq_pkg::ST_DONE;
                case (r_kind)
                    torq_pkg::KIND_ADD: begin
                        if (r_found_hit) begin
                            n_res_present = 1'b1;
                            n_res_pos     = torq_pkg::POS_W'(r_found_idx);
                            n_res_stamp   = r_found_stamp;
                            n_res_status  = torq_pkg::STAT_DUP;
                        end else if (ins_at >= i_slots) begin
                            // full and the new entry would be last
                            o_fill_wr_en          = 1'b1;
                            o_fill_wr_data        = r_len;
                            n_fill_vld[r_res]     = 1'b1;
                            n_res_status          = torq_pkg::STAT_FULL;
                        end else begin
                            o_fill_wr_en      = 1'b1;
                            o_fill_wr_data    = (r_len < i_slots) ? (r_len + CW'(1)) : i_slots;
                            n_fill_vld[r_res] = 1'b1;
                            n_res_present     = 1'b1;
                            n_res_pos         = torq_pkg::POS_W'(ins_at);
                            n_res_stamp       = r_stamp;
                            n_res_status      = (r_len < i_slots) ? torq_pkg::STAT_DONE
                                                                  : torq_pkg::STAT_DROPPED;
                            n_ins             = ins_at;
                            n_back            = 1'b1;
                            if (last_slot > ins_at) begin
                                o_ent_rd_en   = 1'b1;
                                o_ent_rd_addr = r_base + AW'(last_slot - CW'(1));
                                n_idx         = last_slot;
                                n_state       = torq_pkg::ST_SHIFT;
                            end else begin
                                n_state = torq_pkg::ST_PUT;
                            end
                        end
                    end
                    torq_pkg::KIND_REMOVE: begin
                        if (r_found_hit) begin
                            o_fill_wr_en      = 1'b1;
                            o_fill_wr_data    = r_len - CW'(1);
                            n_fill_vld[r_res] = 1'b1;
                            n_res_status      = torq_pkg::STAT_DONE;
                            n_back            = 1'b0;
                            if ((r_found_idx + CW'(1)) < r_len) begin
                                o_ent_rd_en   = 1'b1;
                                o_ent_rd_addr = r_base + AW'(r_found_idx + CW'(1));
                                n_idx         = r_found_idx;
                                n_state       = torq_pkg::ST_SHIFT;
                            end
                        end
                    end
                    default: begin
                        if (r_found_hit) begin
                            n_res_present = 1'b1;
                            n_res_pos     = torq_pkg::POS_W'(r_found_idx);
                            n_res_stamp   = r_found_stamp;
                            n_res_status  = torq_pkg::STAT_DONE;
                        end
                    end
                endcase
            end

            // move one entry per cycle; the read runs one slot ahead of the write
            torq_pkg::ST_SHIFT: begin
                o_ent_wr_en   = 1'b1;
                o_ent_wr_addr = r_base + AW'(r_idx);
                o_ent_wr_data = i_ent_rd_data;
                if (r_back) begin
                    if (r_idx > (r_ins + CW'(1))) begin
                        o_ent_rd_en   = 1'b1;
                        o_ent_rd_addr = r_base + AW'(r_idx - CW'(2));
                        n_idx         = r_idx - CW'(1);
                    end else begin
                        n_state = torq_pkg::ST_PUT;
                    end
                end else begin
                    if ((r_idx + CW'(2)) < r_len) begin
                        o_ent_rd_en   = 1'b1;
                        o_ent_rd_addr = r_base + AW'(r_idx + CW'(2));
                        n_idx         = r_idx + CW'(1);
                    end else begin
                        n_state = torq_pkg::ST_DONE;
                    end
                end
            end

            // new entry into its slot
            torq_pkg::ST_PUT: begin
                o_ent_wr_en   = 1'b1;
                o_ent_wr_addr = r_base + AW'(r_ins);
                o_ent_wr_data = new_ent;
                n_state       = torq_pkg::ST_DONE;
            end

            // hand the result to the output register once it is free
            torq_pkg::ST_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld     = 1'b1;
                    n_out_present = r_res_present;
                    n_out_pos     = r_res_pos;
                    n_out_stamp   = r_res_stamp;
                    n_out_status  = r_res_status;
                    n_state       = torq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = torq_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_req.ready        = (r_state == torq_pkg::ST_IDLE);
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.present      = r_out_present;
    assign o_rsp.position     = r_out_pos;
    assign o_rsp.stored_stamp = r_out_stamp;
    assign o_rsp.status       = r_out_status;

endmodule

>>> design/timestamp_ordered_request_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue_unit
// One sorted request queue per resource, ordered by (timestamp, client);
// add, remove and position query, one response beat per request beat.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  i_cfg    in   active_slots (slot count, 0 acts as 1, clipped to clients)
//  i_req    in   kind, resource, client, stamp
//  o_rsp    out  present, position, stored_stamp, status
//
// A request's run grows with L, the queue length scanned, and M, the number
// of entries moved; an inserting add also passes through the put step.
// The single read port of the entry memory paces both the scan and the shift.
// Reset clears the slot count to 16 and marks every queue empty; no clearing pass.
// A new request is taken while the previous response waits in the output
// register; a stalled response holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue_unit #(
    parameter int NUM_RESOURCES = torq_pkg::DEF_NUM_RESOURCES,
    parameter int NUM_CLIENTS   = torq_pkg::DEF_NUM_CLIENTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    torq_cfg_if.sink    i_cfg,
    torq_req_if.sink    i_req,
    torq_rsp_if.source  o_rsp
);

    localparam int CW    = $clog2(NUM_CLIENTS + 1);
    localparam int RW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int DEPTH = NUM_RESOURCES * NUM_CLIENTS;
    localparam int AW    = $clog2(DEPTH);

    logic [torq_pkg::SLOTS_W-1:0] r_active_slots;
    logic [CW-1:0]                slots;

    logic                         ent_rd_en;
    logic [AW-1:0]                ent_rd_addr;
    logic [torq_pkg::ENTRY_W-1:0] ent_rd_data;
    logic                         ent_wr_en;
    logic [AW-1:0]                ent_wr_addr;
    logic [torq_pkg::ENTRY_W-1:0] ent_wr_data;
    logic                         fill_rd_en;
    logic [RW-1:0]                fill_rd_addr;
    logic [CW-1:0]                fill_rd_data;
    logic                         fill_wr_en;
    logic [RW-1:0]                fill_wr_addr;
    logic [CW-1:0]                fill_wr_data;

    // Slot count register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= torq_pkg::SLOTS_RESET;
        end else if (i_cfg.valid) begin
            r_active_slots <= i_cfg.active_slots;
        end
    end

    // Effective slot count: at least one, at most the client count
    always_comb begin
        if (r_active_slots == '0) begin
            slots = CW'(1);
        end else if (int'(r_active_slots) > NUM_CLIENTS) begin
            slots = CW'(NUM_CLIENTS);
        end else begin
            slots = CW'(r_active_slots);
        end
    end

    torq_seq #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .NUM_CLIENTS   (NUM_CLIENTS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_slots        (slots),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_ent_rd_en    (ent_rd_en),
        .o_ent_rd_addr  (ent_rd_addr),
        .i_ent_rd_data  (ent_rd_data),
        .o_ent_wr_en    (ent_wr_en),
        .o_ent_wr_addr  (ent_wr_addr),
        .o_ent_wr_data  (ent_wr_data),
        .o_fill_rd_en   (fill_rd_en),
        .o_fill_rd_addr (fill_rd_addr),
        .i_fill_rd_data (fill_rd_data),
        .o_fill_wr_en   (fill_wr_en),
        .o_fill_wr_addr (fill_wr_addr),
        .o_fill_wr_data (fill_wr_data)
    );

    // Queue slots, all resources, client and stamp per entry
    torq_ram #(
        .WIDTH (torq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_wr_en),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wr_data),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (ent_rd_addr),
        .o_rd_data (ent_rd_data)
    );

    // Queue length per resource
    torq_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_RESOURCES)
    ) u_fill_ram (
        .i_clk     (i_clk),
        .i_wr_en   (fill_wr_en),
        .i_wr_addr (fill_wr_addr),
        .i_wr_data (fill_wr_data),
        .i_rd_en   (fill_rd_en),
        .i_rd_addr (fill_rd_addr),
        .o_rd_data (fill_rd_data)
    );

endmodule
